// File: src/tcd_pkg.sv
// Package for the tracker cell decoder: note period table, candidate and
// pipeline side-band types, and the tree sizes that follow from the octave count.
// No dependencies.
package tcd_pkg;

   localparam int NUM_OCTAVES = 5;
   localparam int NUM_SEMIS   = 12;
   localparam int NUM_NOTES   = NUM_SEMIS * NUM_OCTAVES;

   // candidates per level of the 4-way minimum tree (three levels reach one)
   localparam int L1_N = (NUM_NOTES + 3) / 4;
   localparam int L2_N = (L1_N + 3) / 4;

   localparam logic [5:0] NO_NOTE   = 6'd63;
   localparam logic [7:0] NO_SAMPLE = 8'd31;
   localparam logic [11:0] DIST_MAX = 12'hFFF;

   localparam logic [10:0] BASE_PERIOD [NUM_SEMIS] = '{
      11'd856, 11'd808, 11'd762, 11'd720, 11'd678, 11'd640,
      11'd604, 11'd570, 11'd538, 11'd508, 11'd480, 11'd453
   };

   typedef struct packed {
      logic [11:0] gap;
      logic [5:0]  idx;
   } cand_type;

   typedef struct packed {
      logic       valid;
      logic       no_note;
      logic [7:0] slot;
      logic [3:0] effect;
      logic [7:0] param;
   } side_type;

   localparam cand_type CAND_PAD = '{gap: DIST_MAX, idx: NO_NOTE};

   // doubled base period shifted right once per octave
   function automatic logic [11:0] note_period(input int oct, input int semi);
      logic [11:0] p;
      p = {BASE_PERIOD[semi], 1'b0};
      return p >> oct;
   endfunction

endpackage

// File: src/tcd_pick4.sv
// Four-way minimum of distance candidates; on equal distance the earlier slot wins.
// Depends on tcd_pkg.
module tcd_pick4 (
   input  tcd_pkg::cand_type cand_i [4],
   output tcd_pkg::cand_type best_o
);

   always_comb begin
      best_o = cand_i[0];
      for (int k = 1; k < 4; k++) begin
         if (cand_i[k].gap < best_o.gap) begin
            best_o = cand_i[k];
         end
      end
   end

endmodule

// File: src/tracker_cell_decoder.sv
// Top level of the tracker cell decoder: five-stage pipeline of field unpack,
// per-note distance, and a registered 4-way minimum tree. Depends on tcd_pkg, tcd_pick4.

// A request is taken whenever start is high; busy is always low, so one cell
// can enter every cycle. Its result appears on the rsp_ ports with rsp_strobe,
// in request order, once the cell, its note distances and each of the three
// levels of the minimum tree over the note distances have been registered.
// Results cannot be held off by the receiver.
module tracker_cell_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_byte_a,
   input  logic [7:0] req_byte_b,
   input  logic [7:0] req_byte_c,
   input  logic [7:0] req_byte_d,
   output logic       rsp_strobe,
   output logic [5:0] rsp_note_index,
   output logic [7:0] rsp_sample_slot,
   output logic [3:0] rsp_effect_code,
   output logic [7:0] rsp_effect_param
);

   // stage 1: unpack
   logic [11:0]       period_ff;
   tcd_pkg::side_type side1_ff, side1_in;
   logic [7:0]        sample;

   // stage 2: distances
   tcd_pkg::cand_type dist_ff [tcd_pkg::NUM_NOTES];
   tcd_pkg::cand_type dist_in [tcd_pkg::NUM_NOTES];
   tcd_pkg::side_type side2_ff;

   // stage 3..5: tree
   tcd_pkg::cand_type lvl1_src [tcd_pkg::L1_N * 4];
   tcd_pkg::cand_type lvl1_ff  [tcd_pkg::L1_N];
   tcd_pkg::cand_type lvl1_in  [tcd_pkg::L1_N];
   tcd_pkg::side_type side3_ff;
   tcd_pkg::cand_type lvl2_src [tcd_pkg::L2_N * 4];
   tcd_pkg::cand_type lvl2_ff  [tcd_pkg::L2_N];
   tcd_pkg::cand_type lvl2_in  [tcd_pkg::L2_N];
   tcd_pkg::side_type side4_ff;
   tcd_pkg::cand_type lvl3_src [4];
   tcd_pkg::cand_type best;
   tcd_pkg::side_type side5_ff;
   logic [5:0]        note_ff;

   assign busy = 1'b0;

   assign sample = {req_byte_a[7:4], req_byte_c[7:4]};

   always_comb begin
      side1_in.valid   = start;
      side1_in.no_note = (req_byte_a[3:0] == 4'd0) && (req_byte_b == 8'd0);
      side1_in.slot    = (sample == 8'd0) ? tcd_pkg::NO_SAMPLE : sample - 8'd1;
      side1_in.effect  = req_byte_c[3:0];
      side1_in.param   = req_byte_d;
   end

   genvar go, gs, gi;
   generate
      for (go = 0; go < tcd_pkg::NUM_OCTAVES; go++) begin : g_oct
         for (gs = 0; gs < tcd_pkg::NUM_SEMIS; gs++) begin : g_semi
            localparam logic [11:0] P = tcd_pkg::note_period(go, gs);
            localparam int IDX = go * tcd_pkg::NUM_SEMIS + gs;
            assign dist_in[IDX].gap = (period_ff >= P) ? period_ff - P : P - period_ff;
            assign dist_in[IDX].idx = 6'(IDX);
         end
      end

      // pad slots sit after every real note, so strict compare never picks them on a tie
      for (gi = 0; gi < tcd_pkg::L1_N * 4; gi++) begin : g_src1
         if (gi < tcd_pkg::NUM_NOTES) begin : g_real
            assign lvl1_src[gi] = dist_ff[gi];
         end else begin : g_pad
            assign lvl1_src[gi] = tcd_pkg::CAND_PAD;
         end
      end
      for (gi = 0; gi < tcd_pkg::L1_N; gi++) begin : g_lvl1
         tcd_pick4 u_pick (.cand_i(lvl1_src[gi*4 +: 4]), .best_o(lvl1_in[gi]));
      end

      for (gi = 0; gi < tcd_pkg::L2_N * 4; gi++) begin : g_src2
         if (gi < tcd_pkg::L1_N) begin : g_real
            assign lvl2_src[gi] = lvl1_ff[gi];
         end else begin : g_pad
            assign lvl2_src[gi] = tcd_pkg::CAND_PAD;
         end
      end
      for (gi = 0; gi < tcd_pkg::L2_N; gi++) begin : g_lvl2
         tcd_pick4 u_pick (.cand_i(lvl2_src[gi*4 +: 4]), .best_o(lvl2_in[gi]));
      end

      for (gi = 0; gi < 4; gi++) begin : g_src3
         if (gi < tcd_pkg::L2_N) begin : g_real
            assign lvl3_src[gi] = lvl2_ff[gi];
         end else begin : g_pad
            assign lvl3_src[gi] = tcd_pkg::CAND_PAD;
         end
      end
   endgenerate

   tcd_pick4 u_pick_last (.cand_i(lvl3_src), .best_o(best));

   // payload
   always_ff @(posedge clock) begin
      period_ff <= {req_byte_a[3:0], req_byte_b};
      dist_ff   <= dist_in;
      lvl1_ff   <= lvl1_in;
      lvl2_ff   <= lvl2_in;
      note_ff   <= side4_ff.no_note ? tcd_pkg::NO_NOTE : best.idx;
   end

   // side band travels with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff <= '0;
         side2_ff <= '0;
         side3_ff <= '0;
         side4_ff <= '0;
         side5_ff <= '0;
      end else begin
         side1_ff <= side1_in;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         side4_ff <= side3_ff;
         side5_ff <= side4_ff;
      end
   end

   assign rsp_strobe       = side5_ff.valid;
   assign rsp_note_index   = note_ff;
   assign rsp_sample_slot  = side5_ff.slot;
   assign rsp_effect_code  = side5_ff.effect;
   assign rsp_effect_param = side5_ff.param;

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      start |-> ##5 rsp_strobe)
      else $error("request did not produce a response after five cycles");

   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      (start && req_byte_a[3:0] == 4'd0 && req_byte_b == 8'd0)
      |-> ##5 (rsp_note_index == tcd_pkg::NO_NOTE))
      else $error("zero period did not give the no-note code");

   a_note_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_note_index != tcd_pkg::NO_NOTE)
      |-> (rsp_note_index < 6'(tcd_pkg::NUM_NOTES)))
      else $error("note index beyond the note table");

   a_nonzero_period: assert property (@(posedge clock) disable iff (reset)
      (start && (req_byte_a[3:0] != 4'd0 || req_byte_b != 8'd0))
      |-> ##5 (rsp_note_index != tcd_pkg::NO_NOTE))
      else $error("nonzero period gave the no-note code");

endmodule
